[hw/rtl/msu_pkg.sv]
// Shared types and constants for the multiset sequence unrank block.
`timescale 1ns / 1ps
package msu_pkg;

  // Payload widths
  localparam int RANK_W     = 63;
  localparam int CNT_W      = 64;
  localparam int VAL_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH = CFG_IDX_W'(1);

  // Register values after reset (before clamping)
  localparam logic [VAL_W-1:0] RST_MAX_VALUE  = VAL_W'(32);
  localparam logic [VAL_W-1:0] RST_SEQ_LENGTH = VAL_W'(1);

  // Shared adder/subtractor
  typedef enum logic {ALU_ADD, ALU_SUB} alu_op_t;

  typedef struct packed {
    logic [CNT_W-1:0] res;
    logic             lt;   // a < b, valid for subtract
  } alu_out_t;

endpackage

[hw/rtl/msu_cfg_if.sv]
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface msu_cfg_if import msu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/msu_rank_if.sv]
// Input channel: one rank per request.
`timescale 1ns / 1ps
interface msu_rank_if import msu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

[hw/rtl/msu_elem_if.sv]
// Output channel: one sequence element per request.
`timescale 1ns / 1ps
interface msu_elem_if import msu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] element_value;
  logic             last;
  logic             out_of_range;

  modport source (output valid, output element_value, output last, output out_of_range,
                  input ready);
  modport sink   (input valid, input element_value, input last, input out_of_range,
                  output ready);
endinterface

[hw/rtl/msu_alu.sv]
// Shared 64-bit add/subtract unit with unsigned less-than flag.
`timescale 1ns / 1ps
module msu_alu import msu_pkg::*; (
  input  alu_op_t          op,
  input  logic [CNT_W-1:0] a,
  input  logic [CNT_W-1:0] b,
  output alu_out_t         y
);

  logic [CNT_W-1:0] b_x;
  logic [CNT_W:0]   full;

  // Subtract as a + ~b + 1; no carry out means a borrow, i.e. a < b
  always_comb begin
    b_x   = (op == ALU_SUB) ? ~b : b;
    full  = {1'b0, a} + {1'b0, b_x} + {{CNT_W{1'b0}}, (op == ALU_SUB)};
    y.res = full[CNT_W-1:0];
    y.lt  = (op == ALU_SUB) && !full[CNT_W];
  end

endmodule

[hw/rtl/multiset_sequence_unrank.sv]
// Top level: count table memory, build and unrank sequencer around the shared adder.
//
//  channel   | dir | payload                               | handshake
//  ----------+-----+---------------------------------------+------------
//  cfg       | in  | index, data                           | valid/ready
//  ranks     | in  | rank                                  | valid/ready
//  elements  | out | element_value, last, out_of_range     | valid/ready
//
// A rank is unranked at one candidate compare per cycle while the output is not stalled,
// through the shared 64-bit subtractor, fed by the count table read port.
// An out-of-range rank gives one flagged request.
// After reset and after every max_value or seq_length write the count table is rebuilt;
// ranks are not taken then.
// A stalled output register holds the sequencer in place until it drains.
`timescale 1ns / 1ps
module multiset_sequence_unrank import msu_pkg::*; #(
  parameter int MAX_VALUE  = 32,
  parameter int MAX_LENGTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  msu_cfg_if.sink    cfg,
  msu_rank_if.sink   ranks,
  msu_elem_if.source elements
);

  localparam int VIDX_W = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1;
  localparam int LIDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam logic [VAL_W-1:0] MAXV = VAL_W'(MAX_VALUE);
  localparam logic [VAL_W-1:0] MAXL = VAL_W'(MAX_LENGTH);

  typedef enum logic [2:0] {
    S_START, S_INIT, S_BRD, S_BWR, S_BTOT, S_IDLE, S_CHK, S_STEP
  } state_t;

  function automatic logic [VAL_W-1:0] clamp(input logic [VAL_W-1:0] d,
                                             input logic [VAL_W-1:0] hi);
    logic [VAL_W-1:0] r;
    if (d == '0)    r = VAL_W'(1);
    else if (d > hi) r = hi;
    else             r = d;
    return r;
  endfunction

  state_t           state;
  logic [VAL_W-1:0] max_val;
  logic [VAL_W-1:0] seq_len;
  logic [VAL_W-1:0] bl;        // build row
  logic [VAL_W-1:0] bv;        // build column
  logic [CNT_W-1:0] acc;       // running suffix sum of previous row
  logic [CNT_W-1:0] tot;       // total sequence count
  logic [CNT_W-1:0] x;         // remaining rank
  logic [VAL_W-1:0] v;         // current candidate, zero based
  logic [VAL_W-1:0] rem;       // remaining length row
  logic             out_valid;
  logic [VAL_W-1:0] out_val;
  logic             out_last;
  logic             out_oor;
  logic [CNT_W-1:0] rdata;

  logic [CNT_W-1:0] cnt_mem [MAX_LENGTH][MAX_VALUE];

  alu_op_t          alu_op;
  logic [CNT_W-1:0] alu_a;
  logic [CNT_W-1:0] alu_b;
  alu_out_t         alu_y;

  logic             can_emit;
  logic             pick;
  logic             stall;
  logic [VAL_W-1:0] rd_row;
  logic [VAL_W-1:0] rd_col;
  logic             we;
  logic [VAL_W-1:0] wr_row;
  logic [CNT_W-1:0] wd;

  msu_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // Handshake outputs
  assign ranks.ready            = (state == S_IDLE);
  assign cfg.ready              = 1'b1;
  assign elements.valid         = out_valid;
  assign elements.element_value = out_val;
  assign elements.last          = out_last;
  assign elements.out_of_range  = out_oor;

  // Shared unit operand select
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = acc;
    alu_b  = rdata;
    unique case (state)
      S_BTOT: begin
        alu_a = tot;
        alu_b = acc;
      end
      S_CHK: begin
        alu_op = ALU_SUB;
        alu_a  = x;
        alu_b  = tot;
      end
      S_STEP: begin
        alu_op = ALU_SUB;
        alu_a  = x;
        alu_b  = rdata;
      end
      default: ;
    endcase
  end

  // Candidate decision; last candidate is taken even if the rank is not below it
  assign can_emit = !out_valid || elements.ready;
  assign pick     = alu_y.lt || (v == max_val - VAL_W'(1));
  assign stall    = pick && !can_emit;

  // Table read address: next candidate is decided in the same cycle
  always_comb begin
    rd_row = '0;
    rd_col = '0;
    unique case (state)
      S_BRD: begin
        rd_row = bl - VAL_W'(1);
        rd_col = bv;
      end
      S_CHK: begin
        rd_row = seq_len - VAL_W'(1);
        rd_col = '0;
      end
      S_STEP: begin
        if (pick && (stall || rem == '0)) begin
          rd_row = rem;
          rd_col = v;
        end else if (pick) begin
          rd_row = rem - VAL_W'(1);
          rd_col = v;
        end else begin
          rd_row = rem;
          rd_col = v + VAL_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Table write: row 0 is all ones, higher rows take the suffix sum
  assign we     = (state == S_INIT) || (state == S_BWR);
  assign wr_row = (state == S_INIT) ? '0 : bl;
  assign wd     = (state == S_INIT) ? CNT_W'(1) : alu_y.res;

  // Count table memory
  always_ff @(posedge clk) begin
    if (we) begin
      cnt_mem[wr_row[LIDX_W-1:0]][bv[VIDX_W-1:0]] <= wd;
    end
    rdata <= cnt_mem[rd_row[LIDX_W-1:0]][rd_col[VIDX_W-1:0]];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_START;
      max_val   <= clamp(RST_MAX_VALUE, MAXV);
      seq_len   <= clamp(RST_SEQ_LENGTH, MAXL);
      out_valid <= 1'b0;
    end else begin
      if (out_valid && elements.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_START: begin
          bv    <= max_val - VAL_W'(1);
          tot   <= '0;
          state <= S_INIT;
        end
        S_INIT: begin
          if (bv == '0) begin
            if (seq_len == VAL_W'(1)) begin
              tot   <= {{(CNT_W-VAL_W){1'b0}}, max_val};
              state <= S_IDLE;
            end else begin
              bl    <= VAL_W'(1);
              bv    <= max_val - VAL_W'(1);
              acc   <= '0;
              state <= S_BRD;
            end
          end else begin
            bv <= bv - VAL_W'(1);
          end
        end
        S_BRD: begin
          state <= S_BWR;
        end
        S_BWR: begin
          acc <= alu_y.res;
          if (bl == seq_len - VAL_W'(1)) begin
            state <= S_BTOT;
          end else if (bv == '0) begin
            bl    <= bl + VAL_W'(1);
            bv    <= max_val - VAL_W'(1);
            acc   <= '0;
            state <= S_BRD;
          end else begin
            bv    <= bv - VAL_W'(1);
            state <= S_BRD;
          end
        end
        S_BTOT: begin
          tot <= alu_y.res;
          if (bv == '0) begin
            state <= S_IDLE;
          end else begin
            bv    <= bv - VAL_W'(1);
            state <= S_BRD;
          end
        end
        S_IDLE: begin
          if (ranks.valid) begin
            x     <= {1'b0, ranks.rank};
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (!alu_y.lt) begin
            if (can_emit) begin
              out_valid <= 1'b1;
              out_val   <= '0;
              out_last  <= 1'b1;
              out_oor   <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            v     <= '0;
            rem   <= seq_len - VAL_W'(1);
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (!stall) begin
            if (!alu_y.lt) begin
              x <= alu_y.res;
            end
            if (pick) begin
              out_valid <= 1'b1;
              out_val   <= v + VAL_W'(1);
              out_last  <= (rem == '0);
              out_oor   <= 1'b0;
              if (rem == '0) begin
                state <= S_IDLE;
              end else begin
                rem <= rem - VAL_W'(1);
              end
            end else begin
              v <= v + VAL_W'(1);
            end
          end
        end
      endcase

      // Register writes restart the table build
      if (cfg.valid) begin
        if (cfg.index == REG_MAX_VALUE) begin
          max_val <= clamp(cfg.data, MAXV);
          state   <= S_START;
        end else if (cfg.index == REG_SEQ_LENGTH) begin
          seq_len <= clamp(cfg.data, MAXL);
          state   <= S_START;
        end
      end
    end
  end

endmodule

[hw/rtl/msu_checker.sv]
// Port-level checks for the multiset sequence unrank block, bound to the top level.
`timescale 1ns / 1ps
module msu_checker import msu_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [VAL_W-1:0]     out_value,
  input logic                 out_last,
  input logic                 out_oor
);

  logic             mid_seq;
  logic [VAL_W-1:0] prev_val;
  logic             cfg_known;

  // Track the last element delivered within the current sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_seq <= 1'b0;
    end else if (out_valid && out_ready) begin
      mid_seq  <= !out_last;
      prev_val <= out_value;
    end
  end

  // Only writes to a real register restart the build
  assign cfg_known = (cfg_index == REG_MAX_VALUE) || (cfg_index == REG_SEQ_LENGTH);

  // Error request is a single flagged request with a zero value
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_oor) |-> (out_value == '0 && out_last))
    else $error("out_of_range request without zero value and last");

  // A good element is never zero
  a_elem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_oor) |-> (out_value != '0))
    else $error("zero element in a valid sequence");

  // Elements within one sequence never decrease
  a_nondecr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mid_seq) |-> (!out_oor && out_value >= prev_val))
    else $error("sequence element decreased");

  // One rank at a time
  a_one_rank: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("rank accepted on back-to-back cycles");

  // A register write starts a table rebuild
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_known) |=> !in_ready)
    else $error("rank input ready right after a register write");

endmodule

bind multiset_sequence_unrank msu_checker u_msu_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready),
  .cfg_index (cfg.index),
  .in_valid  (ranks.valid),
  .in_ready  (ranks.ready),
  .out_valid (elements.valid),
  .out_ready (elements.ready),
  .out_value (elements.element_value),
  .out_last  (elements.last),
  .out_oor   (elements.out_of_range)
);

[verif/tb.sv]
// Self-checking testbench for the multiset sequence unrank block.
`timescale 1ns / 1ps
module tb;
  import msu_pkg::*;

  localparam int MAX_VAL       = 32;
  localparam int MAX_LEN       = 32;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 300;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam logic [RANK_W-1:0] RANK_ALL_ONES = {RANK_W{1'b1}};

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
    logic             oor;
  } elem_t;

  logic clk;
  logic rst;

  msu_cfg_if  cfg_bus ();
  msu_rank_if rank_bus ();
  msu_elem_if elem_bus ();

  multiset_sequence_unrank #(
    .MAX_VALUE (MAX_VAL),
    .MAX_LENGTH(MAX_LEN)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .ranks   (rank_bus),
    .elements(elem_bus)
  );

  // Predictor state: register copies and count table
  logic [VAL_W-1:0] cur_max;
  logic [VAL_W-1:0] cur_len;
  logic [CNT_W-1:0] seq_counts [MAX_LEN][MAX_VAL];

  elem_t pending_elems[$];
  int    errors;
  int    cycles;
  int    idle_pct;
  int    hold_ask;
  int    hold_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL multiset_sequence_unrank");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [VAL_W-1:0] clamp_reg(input logic [VAL_W-1:0] d, input int hi);
    if (d == 0) return VAL_W'(1);
    if (d > hi) return VAL_W'(hi);
    return d;
  endfunction

  // Count of non-decreasing sequences per remaining length and start value
  function automatic void rebuild_counts();
    logic [CNT_W-1:0] sum;
    for (int l = 0; l < MAX_LEN; l++)
      for (int v = 0; v < MAX_VAL; v++)
        seq_counts[l][v] = '0;
    for (int v = 0; v < cur_max; v++)
      seq_counts[0][v] = CNT_W'(1);
    for (int l = 1; l < cur_len; l++) begin
      for (int v = 0; v < cur_max; v++) begin
        sum = '0;
        for (int w = v; w < cur_max; w++)
          sum += seq_counts[l-1][w];
        seq_counts[l][v] = sum;
      end
    end
  endfunction

  function automatic logic [CNT_W-1:0] seq_total();
    logic [CNT_W-1:0] t;
    t = '0;
    for (int v = 0; v < cur_max; v++)
      t += seq_counts[cur_len-1][v];
    return t;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] d);
    if (idx == REG_MAX_VALUE)
      cur_max = clamp_reg(d, MAX_VAL);
    else if (idx == REG_SEQ_LENGTH)
      cur_len = clamp_reg(d, MAX_LEN);
    else
      return;
    rebuild_counts();
  endfunction

  // Expected elements for one rank
  function automatic void unrank_predict(input logic [RANK_W-1:0] r);
    logic [CNT_W-1:0] x;
    int    prev;
    int    pick;
    int    rem;
    elem_t e;
    x = CNT_W'(r);
    if (x >= seq_total()) begin
      e = '{value: '0, last: 1'b1, oor: 1'b1};
      pending_elems = {pending_elems, e};
      return;
    end
    prev = 0;
    for (int pos = 0; pos < cur_len; pos++) begin
      rem  = cur_len - 1 - pos;
      pick = cur_max - 1;
      for (int v = prev; v < cur_max; v++) begin
        if (x < seq_counts[rem][v]) begin
          pick = v;
          break;
        end
        x -= seq_counts[rem][v];
      end
      prev = pick;
      e = '{value: VAL_W'(pick + 1), last: (pos + 1 == cur_len), oor: 1'b0};
      pending_elems = {pending_elems, e};
    end
  endfunction

  // Output ready: random stalls, or a long hold when asked
  always @(posedge clk) begin
    if (hold_ask > 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (hold_left > 0) begin
      elem_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      elem_bus.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Compare each accepted element with the oldest expectation
  always @(posedge clk) begin
    elem_t want;
    if (!rst && elem_bus.valid && elem_bus.ready) begin
      if (pending_elems.size() == 0) begin
        report_mismatch($sformatf("unexpected element value=%0d last=%0b oor=%0b",
                                  elem_bus.element_value, elem_bus.last,
                                  elem_bus.out_of_range));
      end else begin
        want = pending_elems.pop_front();
        if (elem_bus.element_value !== want.value)
          report_mismatch($sformatf("element_value got %0d want %0d",
                                    elem_bus.element_value, want.value));
        if (elem_bus.last !== want.last)
          report_mismatch($sformatf("last got %b want %b", elem_bus.last, want.last));
        if (elem_bus.out_of_range !== want.oor)
          report_mismatch($sformatf("out_of_range got %b want %b",
                                    elem_bus.out_of_range, want.oor));
      end
    end
  end

  // One rank request; valid stays high into the next request when no gap is drawn
  task automatic send_rank(input logic [RANK_W-1:0] r);
    if ($urandom_range(99) < idle_pct) begin
      rank_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    rank_bus.valid <= 1'b1;
    rank_bus.rank  <= r;
    do @(posedge clk); while (!rank_bus.ready);
    unrank_predict(r);
  endtask

  // Drop rank valid and wait until every expected element is back
  task automatic settle();
    rank_bus.valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    apply_reg_write(idx, d);
  endtask

  function automatic logic [RANK_W-1:0] random_rank();
    logic [CNT_W-1:0] t;
    logic [CNT_W-1:0] raw;
    int sel;
    t   = seq_total();
    raw = {$urandom, $urandom};
    sel = $urandom_range(99);
    if (sel < 80) return RANK_W'(raw % t);
    if (sel < 88) return RANK_W'(t + CNT_W'($urandom_range(3)));
    if (sel < 96) return raw[RANK_W-1:0];
    return RANK_ALL_ONES;
  endfunction

  // Register values after reset: single-element sequences over 1..32
  task automatic test_reset_defaults();
    send_rank('0);
    send_rank(RANK_W'(31));
    send_rank(RANK_W'(32));
    send_rank(RANK_W'(5));
    send_rank(RANK_ALL_ONES);
    settle();
  endtask

  // Zero and oversize writes clamp; single value gives a run of ones
  task automatic test_register_clamp();
    write_reg(REG_MAX_VALUE, CFG_DATA_W'(0));
    write_reg(REG_SEQ_LENGTH, CFG_DATA_W'(63));
    send_rank('0);
    send_rank(RANK_W'(1));
    settle();
    // unused indexes leave the setup alone
    write_reg(REG_SPARE_A, CFG_DATA_W'(63));
    write_reg(REG_SPARE_B, CFG_DATA_W'(0));
    send_rank('0);
    settle();
  endtask

  // Largest setup: first, last, middle, just past the end, a far out-of-range rank and rank one
  task automatic test_largest_set();
    logic [CNT_W-1:0] t;
    write_reg(REG_MAX_VALUE, CFG_DATA_W'(63));
    write_reg(REG_SEQ_LENGTH, CFG_DATA_W'(32));
    t = seq_total();
    send_rank('0);
    send_rank(RANK_W'(t - 1));
    send_rank(RANK_W'(t >> 1));
    send_rank(RANK_W'(t));
    send_rank(RANK_W'(1) << 62);
    send_rank(RANK_W'(1));
    settle();
  endtask

  // Long output hold while ranks keep coming, so the input stalls
  task automatic test_backpressure();
    write_reg(REG_MAX_VALUE, CFG_DATA_W'(4));
    write_reg(REG_SEQ_LENGTH, CFG_DATA_W'(16));
    idle_pct = 0;
    hold_ask = HOLD_CYCLES;
    repeat (24) send_rank(random_rank());
    settle();
    idle_pct = 36;
  endtask

  // Random setups, each followed by a batch of random ranks
  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] mv;
    logic [CFG_DATA_W-1:0] sl;
    for (int ph = 0; ph < 8; ph++) begin
      mv = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(63))
                                    : CFG_DATA_W'($urandom_range(32, 1));
      sl = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(63))
                                    : CFG_DATA_W'($urandom_range(32, 1));
      write_reg(REG_MAX_VALUE, mv);
      write_reg(REG_SEQ_LENGTH, sl);
      if ($urandom_range(3) == 0)
        write_reg(($urandom_range(1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_DATA_W'($urandom));
      // one phase runs without any idling
      idle_pct = (ph == 3) ? 0 : 36;
      repeat (37) send_rank(random_rank());
      settle();
    end
    idle_pct = 36;
  endtask

  initial begin
    rst            = 1'b1;
    errors         = 0;
    cycles         = 0;
    idle_pct       = 36;
    hold_ask       = 0;
    hold_left      = 0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_MAX_VALUE;
    cfg_bus.data   = '0;
    rank_bus.valid = 1'b0;
    rank_bus.rank  = '0;
    elem_bus.ready = 1'b0;
    cur_max        = clamp_reg(RST_MAX_VALUE, MAX_VAL);
    cur_len        = clamp_reg(RST_SEQ_LENGTH, MAX_LEN);
    rebuild_counts();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_register_clamp();
    test_largest_set();
    test_backpressure();
    test_random_phases();

    settle();
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("PASS multiset_sequence_unrank");
    else
      $display("FAIL multiset_sequence_unrank");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/msu_pkg.sv
hw/rtl/msu_cfg_if.sv
hw/rtl/msu_rank_if.sv
hw/rtl/msu_elem_if.sv
hw/rtl/msu_alu.sv
hw/rtl/multiset_sequence_unrank.sv
hw/rtl/msu_checker.sv
verif/tb.sv
